@@ src/mhdp_pkg.sv @@
// Shared types and constants for the monotone hull step block.
// No dependencies; used by mhdp_div and monotone_hull_dp_step_top.
package mhdp_pkg;

    localparam int HullDepth = 4096;              // power of two
    localparam int AddrW     = $clog2(HullDepth);
    localparam int CntW      = AddrW + 1;

    localparam int HeightW = 20;
    localparam int JumpW   = 40;
    localparam int CostW   = 62;
    localparam int SlopeW  = 22;
    localparam int WideW   = 64;
    localparam int DenW    = 22;

    localparam logic signed [WideW:0] CostMax = 65'sh0_3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [SlopeW-1:0] slope;
        logic signed [WideW-1:0]  icpt;
        logic signed [WideW-1:0]  start_x;
    } t_line;

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QCHK, S_QMUL, S_QSUM, S_INS0, S_INS1,
        S_DIVW, S_INS2, S_WR, S_OUT
    } t_state;

endpackage

@@ src/monotone_hull_dp_step_top.sv @@
// Monotone convex hull trick step: one cost result per height request.
// Depends on mhdp_pkg and mhdp_div.
//
// A start request, or any request while the hull is empty, skips the query and
// the division. A request that inserts a line behind others waits on the
// 63-step bit-serial divider, which sets the rate; each front line popped adds
// a read and each back line popped adds a division. A request whose line is
// not below the back line skips the division. Pops are amortized; o_in_stall
// holds off each new request until the last result is registered at the output.
// The line store is one 4096-entry single-port memory with registered reads;
// its contents need no clearing after reset. hull_full sets once a line was
// dropped for lack of room and stays set until the next start request.
module monotone_hull_dp_step_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mhdp_pkg::JumpW-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mhdp_pkg::HeightW-1:0]         i_height,
    input  logic                                 i_start_req,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [mhdp_pkg::CostW-1:0]           o_cost,
    output logic                                 o_hull_full
);
    localparam int AW = mhdp_pkg::AddrW;
    localparam int CW = mhdp_pkg::CntW;
    localparam int WW = mhdp_pkg::WideW;

    mhdp_pkg::t_line mem [mhdp_pkg::HullDepth];
    mhdp_pkg::t_line r_rd;

    mhdp_pkg::t_state r_state, n_state;

    logic [AW-1:0]              r_front;
    logic [CW-1:0]              r_count;
    logic                       r_ovf;
    logic [mhdp_pkg::JumpW-1:0] r_jump;
    logic [mhdp_pkg::HeightW-1:0] r_h;
    logic [2*mhdp_pkg::HeightW-1:0] r_hsq;
    logic signed [WW-1:0]       r_prod;
    logic signed [WW-1:0]       r_b;
    logic [mhdp_pkg::JumpW:0]   r_t;
    logic signed [WW-1:0]       r_cost;
    logic signed [WW-1:0]       r_nb;
    logic signed [WW-1:0]       r_x0;
    logic signed [WW-1:0]       r_bsx;
    logic                       r_popchk;
    logic                       r_out_valid;
    logic [mhdp_pkg::CostW-1:0] r_out_cost;
    logic                       r_out_full;

    logic                       w_accept;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic                       div_start;
    logic                       div_done;
    logic signed [WW-1:0]       div_q;
    logic signed [mhdp_pkg::SlopeW-1:0] w_ns;
    logic signed [WW-1:0]       w_num;
    logic [mhdp_pkg::DenW-1:0]  w_den;
    logic signed [mhdp_pkg::SlopeW+mhdp_pkg::HeightW:0] w_prod;
    logic signed [WW:0]         w_sum;
    logic signed [WW-1:0]       w_sat;
    logic signed [WW-1:0]       w_hs;

    assign o_in_stall = (r_state != mhdp_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ns       = -$signed({1'b0, r_h, 1'b0});
    assign w_hs       = $signed({{(WW-mhdp_pkg::HeightW){1'b0}}, r_h});
    assign w_num      = r_nb - r_rd.icpt;
    // slopes fall strictly along the hull, so the difference is positive
    assign w_den      = r_rd.slope - w_ns;
    assign w_prod     = r_rd.slope * $signed({1'b0, r_h});
    assign w_sum      = {r_prod[WW-1], r_prod} + {r_b[WW-1], r_b} +
                        $signed({{(WW-mhdp_pkg::JumpW){1'b0}}, r_t});
    assign w_sat      = (w_sum > mhdp_pkg::CostMax) ? mhdp_pkg::CostMax[WW-1:0] :
                        (w_sum < 0) ? '0 : w_sum[WW-1:0];

    mhdp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // line store
    always_ff @(posedge i_clk) begin
        if (rd_en)
            r_rd <= mem[rd_addr];
        if (wr_en)
            mem[r_front + r_count[AW-1:0]] <= '{slope: w_ns, icpt: r_nb, start_x: r_x0};
    end

    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        rd_addr   = r_front;
        wr_en     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            mhdp_pkg::S_IDLE: begin
                if (w_accept)
                    n_state = (i_start_req || r_count == '0) ? mhdp_pkg::S_INS0
                                                             : mhdp_pkg::S_QRD;
            end
            mhdp_pkg::S_QRD: begin
                rd_en = 1'b1;
                if (r_count > CW'(1)) begin
                    rd_addr = r_front + AW'(1);
                    n_state = mhdp_pkg::S_QCHK;
                end else begin
                    n_state = mhdp_pkg::S_QMUL;
                end
            end
            mhdp_pkg::S_QCHK: begin
                if (r_rd.start_x <= w_hs) begin
                    n_state = mhdp_pkg::S_QRD;
                end else begin
                    rd_en   = 1'b1;
                    n_state = mhdp_pkg::S_QMUL;
                end
            end
            mhdp_pkg::S_QMUL: n_state = mhdp_pkg::S_QSUM;
            mhdp_pkg::S_QSUM: n_state = mhdp_pkg::S_INS0;
            mhdp_pkg::S_INS0: begin
                if (r_count != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_front + r_count[AW-1:0] - AW'(1);
                    n_state = mhdp_pkg::S_INS1;
                end else begin
                    n_state = mhdp_pkg::S_WR;
                end
            end
            mhdp_pkg::S_INS1: begin
                if (w_ns >= r_rd.slope) begin
                    n_state = mhdp_pkg::S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = mhdp_pkg::S_DIVW;
                end
            end
            mhdp_pkg::S_DIVW: begin
                if (div_done) begin
                    if (r_popchk && r_bsx >= div_q) begin
                        rd_en   = 1'b1;
                        rd_addr = r_front + r_count[AW-1:0] - AW'(2);
                        n_state = mhdp_pkg::S_INS2;
                    end else begin
                        n_state = mhdp_pkg::S_WR;
                    end
                end
            end
            mhdp_pkg::S_INS2: begin
                div_start = 1'b1;
                n_state   = mhdp_pkg::S_DIVW;
            end
            mhdp_pkg::S_WR: begin
                wr_en   = (r_count < CW'(mhdp_pkg::HullDepth));
                n_state = mhdp_pkg::S_OUT;
            end
            mhdp_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall)
                    n_state = mhdp_pkg::S_IDLE;
            end
            default: n_state = mhdp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= mhdp_pkg::S_IDLE;
        else
            r_state <= n_state;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_jump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_jump <= i_cfg_data;
            if (r_state == mhdp_pkg::S_OUT && (!r_out_valid || !i_out_stall))
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            case (r_state)
                mhdp_pkg::S_IDLE: begin
                    if (w_accept && (i_start_req || r_count == '0)) begin
                        r_front <= '0;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                mhdp_pkg::S_QCHK: begin
                    // drop a stale front line
                    if (r_rd.start_x <= w_hs) begin
                        r_front <= r_front + AW'(1);
                        r_count <= r_count - CW'(1);
                    end
                end
                mhdp_pkg::S_DIVW: begin
                    if (div_done && r_popchk && r_bsx >= div_q)
                        r_count <= r_count - CW'(1);
                end
                mhdp_pkg::S_WR: begin
                    if (r_count < CW'(mhdp_pkg::HullDepth))
                        r_count <= r_count + CW'(1);
                    else
                        r_ovf <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mhdp_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_h     <= i_height;
                    r_hsq   <= i_height * i_height;
                    r_cost  <= '0;
                end
            end
            mhdp_pkg::S_QMUL: begin
                r_prod <= WW'(w_prod);
                r_b    <= r_rd.icpt;
                r_t    <= {1'b0, r_jump} + (mhdp_pkg::JumpW+1)'(r_hsq);
            end
            mhdp_pkg::S_QSUM: r_cost <= w_sat;
            mhdp_pkg::S_INS0: begin
                r_nb <= r_cost + $signed({{(WW-2*mhdp_pkg::HeightW){1'b0}}, r_hsq});
                r_x0 <= '0;
            end
            mhdp_pkg::S_INS1, mhdp_pkg::S_INS2: begin
                r_bsx    <= r_rd.start_x;
                r_popchk <= r_count > CW'(1);
            end
            mhdp_pkg::S_DIVW: begin
                if (div_done)
                    r_x0 <= div_q;
            end
            mhdp_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out_cost <= r_cost[mhdp_pkg::CostW-1:0];
                    r_out_full <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_cost      = r_out_cost;
    assign o_hull_full = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(mhdp_pkg::HullDepth))
        else $error("line count beyond store depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != mhdp_pkg::S_IDLE)
        else $error("request accepted without leaving idle");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == mhdp_pkg::S_DIVW)
        else $error("divider finished outside its wait state");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_count < CW'(mhdp_pkg::HullDepth))
        else $error("line written into a full store");

endmodule

@@ src/mhdp_div.sv @@
// Bit-serial signed-by-positive divider returning the ceiling of num/den.
// Depends on mhdp_pkg for widths.
module mhdp_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mhdp_pkg::WideW-1:0]    i_num,
    input  logic        [mhdp_pkg::DenW-1:0]     i_den,
    output logic                                 o_done,
    output logic signed [mhdp_pkg::WideW-1:0]    o_quot
);
    localparam int MagW = mhdp_pkg::WideW - 1;

    logic                          r_busy, n_busy;
    logic                          r_done;
    logic [5:0]                    r_cnt;
    logic                          r_neg;
    logic [MagW-1:0]               r_q;
    logic [mhdp_pkg::DenW:0]       r_rem;
    logic [mhdp_pkg::DenW-1:0]     r_den;
    logic [mhdp_pkg::DenW:0]       w_shift;
    logic [mhdp_pkg::DenW:0]       w_diff;
    logic                          w_ge;
    logic [MagW-1:0]               w_abs;

    assign w_abs   = i_num[mhdp_pkg::WideW-1] ? MagW'(-i_num) : i_num[MagW-1:0];
    assign w_shift = {r_rem[mhdp_pkg::DenW-1:0], r_q[MagW-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign n_busy  = i_start ? 1'b1 : (r_busy && r_cnt != 6'(MagW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy;
            r_cnt  <= i_start ? '0 : r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[mhdp_pkg::WideW-1];
            r_q   <= w_abs;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_shift;
            r_q   <= {r_q[MagW-2:0], w_ge};
        end
    end

    // Truncated magnitude is r_q once the loop ends; round up for positive
    // numerators with a remainder, negate for negative ones.
    always_comb begin
        if (r_neg)
            o_quot = -$signed({1'b0, r_q});
        else
            o_quot = $signed({1'b0, r_q}) + ((r_rem != '0) ? 64'sd1 : 64'sd0);
    end
    assign o_done = r_done;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for monotone_hull_dp_step_top: random height requests
// are scored against an in-bench hull predictor. Depends on mhdp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    localparam int     HeightW    = mhdp_pkg::HeightW;
    localparam int     JumpW      = mhdp_pkg::JumpW;
    localparam int     CostW      = mhdp_pkg::CostW;
    localparam int     HullDepth  = mhdp_pkg::HullDepth;
    localparam longint CostLimit  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint JumpTop    = 64'hFF_FFFF_FFFF;
    localparam int     HeightTop  = (1 << HeightW) - 1;
    localparam int     IdleLimit  = 400000;

    typedef struct {
        logic [HeightW-1:0] height;
        logic               start;
    } t_height_req;

    typedef struct {
        logic [CostW-1:0] cost;
        logic             full;
    } t_cost_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [JumpW-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [HeightW-1:0]   i_height = '0;
    logic                 i_start_req = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CostW-1:0]     o_cost;
    logic                 o_hull_full;

    monotone_hull_dp_step_top u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hull predictor state
    longint hull_slope [HullDepth];
    longint hull_icpt  [HullDepth];
    longint hull_x0    [HullDepth];
    int     hull_front;
    int     hull_count;
    bit     hull_over;
    longint jump_amt;

    t_height_req pending_reqs[$];
    t_cost_res   cost_queue[$];
    int errors, accepted_reqs, checked_costs, full_seen;
    bit rst_done;
    bit req_took;

    function automatic int hull_slot(int k);
        return (hull_front + k) % HullDepth;
    endfunction

    function automatic longint meet_x(int s, longint ns, longint nb);
        longint num, den, q;
        num = nb - hull_icpt[s];
        den = hull_slope[s] - ns;
        q = num / den;
        if (num > 0 && num % den != 0) q++;
        return q;
    endfunction

    function automatic void hull_add(longint ns, longint nb);
        longint x0;
        int s;
        x0 = 0;
        if (hull_count > 0 && ns >= hull_slope[hull_slot(hull_count - 1)]) return;
        while (hull_count > 1) begin
            s = hull_slot(hull_count - 1);
            if (hull_x0[s] >= meet_x(s, ns, nb)) hull_count--;
            else break;
        end
        if (hull_count > 0) x0 = meet_x(hull_slot(hull_count - 1), ns, nb);
        if (hull_count >= HullDepth) begin
            hull_over = 1'b1;
            return;
        end
        s = hull_slot(hull_count);
        hull_slope[s] = ns;
        hull_icpt[s] = nb;
        hull_x0[s] = x0;
        hull_count++;
    endfunction

    function automatic t_cost_res predict_cost(t_height_req r);
        longint h, c;
        int f;
        t_cost_res res;
        h = longint'(r.height);
        if (r.start || hull_count == 0) begin
            hull_front = 0;
            hull_count = 0;
            hull_over = 1'b0;
            c = 0;
            hull_add(-2 * h, h * h);
        end else begin
            while (hull_count > 1 && hull_x0[hull_slot(1)] <= h) begin
                hull_front = hull_slot(1);
                hull_count--;
            end
            f = hull_slot(0);
            c = hull_slope[f] * h + hull_icpt[f] + h * h + jump_amt;
            if (c > CostLimit) c = CostLimit;
            if (c < 0) c = 0;
            hull_add(-2 * h, c + h * h);
        end
        res.cost = c[CostW-1:0];
        res.full = hull_over;
        return res;
    endfunction

    // monitor: score requests and results at the rising edge
    always @(posedge i_clk) begin
        t_cost_res want;
        req_took <= i_in_valid && !o_in_stall && i_rst_n;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            cost_queue.push_back(predict_cost('{i_height, i_start_req}));
            accepted_reqs++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cost_queue.size() == 0) begin
                $display("%0t: unexpected result cost=%0d full=%0b", $time, o_cost, o_hull_full);
                errors++;
            end else begin
                want = cost_queue[0];
                cost_queue.delete(0);
                if (o_cost !== want.cost) begin
                    $display("%0t: cost expected %0d actual %0d", $time, want.cost, o_cost);
                    errors++;
                end
                if (o_hull_full !== want.full) begin
                    $display("%0t: hull_full expected %0b actual %0b",
                             $time, want.full, o_hull_full);
                    errors++;
                end
                if (o_hull_full === 1'b1) full_seen++;
                checked_costs++;
            end
        end
    end

    // driver: bursts of requests with random gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_height_req r;
        logic nv;
        nv = i_in_valid;
        if (rst_done && (!i_in_valid || req_took)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs[0];
                pending_reqs.delete(0);
                nv = 1'b1;
                i_height <= r.height;
                i_start_req <= r.start;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom % 2) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        i_in_valid <= nv;
    end

    // receiver stall pattern: free, light or heavy, in randomly chosen modes
    int stall_cyc = 0;
    int stall_mode = 0;
    always @(negedge i_clk) begin
        stall_cyc++;
        if (stall_cyc % 200 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom % 4 == 0);
            default: i_out_stall <= ($urandom % 8 != 0);
        endcase
    end

    // watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: no progress for %0d cycles", $time, IdleLimit);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_req(int h, bit s);
        pending_reqs.push_back('{h[HeightW-1:0], s});
    endtask

    task automatic write_jump(longint v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[JumpW-1:0];
        jump_amt = v & JumpTop;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || cost_queue.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // one increasing run, with some noise and out-of-order heights mixed in
    task automatic add_sequence(ref int count);
        int h, len, stp;
        h = ($urandom % 3 == 0) ? $urandom_range(0, HeightTop) : $urandom_range(0, 4095);
        len = ($urandom % 10 == 0) ? $urandom_range(40, 150) : $urandom_range(1, 30);
        add_req(h, 1'b1);
        count++;
        for (int k = 1; k < len; k++) begin
            if ($urandom % 20 == 0) begin
                add_req($urandom_range(0, HeightTop), ($urandom % 4 == 0));
            end else begin
                stp = $urandom_range(1, 1 << $urandom_range(0, 14));
                if (h + stp > HeightTop) break;
                h += stp;
                add_req(h, 1'b0);
            end
            count++;
        end
    endtask

    initial begin
        int pushed;
        jump_amt = 0;
        hull_front = 0;
        hull_count = 0;
        hull_over = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // directed: empty hull without start, extremes, repeats and drops
        add_req(5, 1'b0);
        add_req(7, 1'b0);
        add_req(0, 1'b1);
        add_req(1, 1'b0);
        add_req(2, 1'b0);
        add_req(2, 1'b0);
        add_req(1, 1'b0);
        add_req(HeightTop, 1'b0);
        add_req(HeightTop, 1'b1);
        add_req(0, 1'b1);
        add_req(HeightTop, 1'b0);
        add_req(HeightTop, 1'b0);
        add_req(1000, 1'b1);
        for (int k = 1; k <= 8; k++) add_req(1000 + k * k * 37, 1'b0);
        add_req(20'hAAAAA, 1'b0);
        add_req(20'h55555, 1'b1);
        add_req(20'hAAAAA, 1'b0);
        drain();

        write_jump(JumpTop);
        add_req(0, 1'b1);
        add_req(HeightTop, 1'b0);
        add_req(3, 1'b1);
        for (int k = 1; k <= 5; k++) add_req(3 + k * 1000, 1'b0);
        drain();

        pushed = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_jump(0);
                1: write_jump(longint'($urandom_range(0, 100000)));
                2: write_jump(64'd1000000000000);
                default: write_jump({$urandom, $urandom} & JumpTop);
            endcase
            while (pushed < (ph + 1) * 310) add_sequence(pushed);
            drain();
        end

        $display("Checked %0d results from %0d requests over several jump cost settings,",
                 checked_costs, accepted_reqs);
        $display("hull_full seen set on %0d results", full_seen);
        if (errors == 0 && cost_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
